[rtl/csm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package csm_pkg;

	// Number of time fields per schedule entry: minute, hour, day of month, month, weekday.
	localparam int FIELDS = 5;

	// Field widths of one input item.
	localparam int KIND_W  = 2;
	localparam int ENTRY_W = 6;
	localparam int FIELD_W = 3;
	localparam int MODE_W  = 2;
	localparam int VAL_W   = 7;
	localparam int MIN_W   = 6;
	localparam int HOUR_W  = 5;
	localparam int DOM_W   = 5;
	localparam int MON_W   = 4;
	localparam int DOW_W   = 3;

	// Stream data widths, rounded up to whole bytes.
	localparam int IN_DATA_W  = 48;
	localparam int OUT_DATA_W = 8;

	// One stored field specification: mode, low value, high value (or list count).
	localparam int SPEC_W = MODE_W + 2 * VAL_W;

	localparam logic [DOW_W-1:0] SUNDAY = 3'd7;

	typedef enum logic [KIND_W-1:0] {
		KIND_SPEC   = 2'd0,
		KIND_SLOT   = 2'd1,
		KIND_ENABLE = 2'd2,
		KIND_TICK   = 2'd3
	} kind_t;

	typedef enum logic [MODE_W-1:0] {
		MODE_ANY   = 2'd0,
		MODE_EXACT = 2'd1,
		MODE_LIST  = 2'd2,
		MODE_RANGE = 2'd3
	} mode_t;

endpackage

`default_nettype wire

[rtl/cron_schedule_matcher.sv]
`timescale 1ns / 1ps
`default_nettype none

// Schedule matcher for cron-style time fields. The block keeps ENTRIES schedule entries in one
// synchronous memory, one row per entry, each row holding the enable bit and the five field
// specifications (minute, hour, day of month, month, weekday) with their LIST_SLOTS list values.
// Input transfers carry a kind in s_axis_tuser: set a field specification, write a list slot,
// set an entry enable, or a tick that carries the current time. A write is a read-modify-write
// of one row, through a read state and a modify state, before the next input transfer is taken.
// A tick scans all entries in ascending order, one row read per cycle, and returns one output
// transfer per enabled entry whose five fields all match (the two day fields are ANDed like the
// others); the final match of a tick carries m_axis_tlast. A tick with no match gives no output.
// A result that cannot leave the output register while a newer match arrives stalls the scan.
// After reset the block sweeps the memory to zero, one row per cycle, and takes no input until
// the sweep is done. The output register lets the block accept its next input transfer while
// the last result still waits to be taken.
module cron_schedule_matcher #(
	parameter int ENTRIES    = 64,
	parameter int LIST_SLOTS = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// From bit 0: entry_index, field_index, spec_mode, first_value, second_value,
	// minute, hour, day_of_month, month, day_of_week.
	input  wire logic [csm_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// kind
	input  wire logic [csm_pkg::KIND_W-1:0]       s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// From bit 0: matched_entry, zero padding.
	output logic      [csm_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	// last_match
	output logic                                   m_axis_tlast
);

	import csm_pkg::*;

	localparam int AW     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW     = $clog2(ENTRIES + 1);
	localparam int FW     = SPEC_W + LIST_SLOTS * VAL_W;
	localparam int EN_BIT = FIELDS * FW;
	localparam int RW     = EN_BIT + 1;

	// Bit positions of the input fields in s_axis_tdata.
	localparam int OFF_ENTRY  = 0;
	localparam int OFF_FIELD  = OFF_ENTRY + ENTRY_W;
	localparam int OFF_MODE   = OFF_FIELD + FIELD_W;
	localparam int OFF_FIRST  = OFF_MODE + MODE_W;
	localparam int OFF_SECOND = OFF_FIRST + VAL_W;
	localparam int OFF_MIN    = OFF_SECOND + VAL_W;
	localparam int OFF_HOUR   = OFF_MIN + MIN_W;
	localparam int OFF_DOM    = OFF_HOUR + HOUR_W;
	localparam int OFF_MON    = OFF_DOM + DOM_W;
	localparam int OFF_DOW    = OFF_MON + MON_W;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_WR_READ,
		ST_WR_MODIFY,
		ST_SCAN,
		ST_FLUSH
	} state_t;

	state_t state_q;

	// Latched input transfer.
	kind_t             kind_q;
	logic [ENTRY_W-1:0] entry_q;
	logic [FIELD_W-1:0] field_q;
	logic [MODE_W-1:0]  mode_q;
	logic [VAL_W-1:0]   first_q;
	logic [VAL_W-1:0]   second_q;
	logic [MIN_W-1:0]   min_q;
	logic [HOUR_W-1:0]  hour_q;
	logic [DOM_W-1:0]   dom_q;
	logic [MON_W-1:0]   mon_q;
	logic [DOW_W-1:0]   dow_q;

	// Row counter for the clearing sweep and the scan; it reaches ENTRIES at the end of a scan.
	logic [CW-1:0] rd_addr_q;

	// Row whose data sits at the memory output.
	logic          vld_s1;
	logic [AW-1:0] idx_s1;

	// The newest match is held back until the next one, or the end of the scan, shows
	// whether it is the last one of the tick.
	logic          pend_vld_q;
	logic [AW-1:0] pend_idx_q;

	logic               out_vld_q;
	logic [ENTRY_W-1:0] out_idx_q;
	logic               out_last_q;

	// Input field views.
	kind_t              in_kind;
	logic [ENTRY_W-1:0] in_entry;
	logic [FIELD_W-1:0] in_field;
	logic [VAL_W-1:0]   in_second;
	logic [DOW_W-1:0]   in_dow;
	logic               write_ok;

	// Memory port.
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [RW-1:0] ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	logic [RW-1:0] ram_rdata;
	logic [RW-1:0] new_row;

	logic [VAL_W-1:0]  now_val [FIELDS];
	logic [FIELDS-1:0] fld_hit;
	logic              entry_hit;
	logic              out_free;
	logic              out_load;
	logic              scan_adv;
	logic              scan_more;

	assign in_kind   = kind_t'(s_axis_tuser);
	assign in_entry  = s_axis_tdata[OFF_ENTRY +: ENTRY_W];
	assign in_field  = s_axis_tdata[OFF_FIELD +: FIELD_W];
	assign in_second = s_axis_tdata[OFF_SECOND +: VAL_W];
	assign in_dow    = s_axis_tdata[OFF_DOW +: DOW_W];

	// Writes to an entry beyond the table, a field beyond the weekday, or a slot beyond the list
	// change nothing, so they skip the memory access altogether.
	assign write_ok = (int'(in_entry) < ENTRIES) &&
	                  ((in_kind == KIND_ENABLE) ||
	                   ((in_field < FIELD_W'(FIELDS)) &&
	                    ((in_kind == KIND_SPEC) || (int'(in_second) < LIST_SLOTS))));

	assign s_axis_tready = (state_q == ST_IDLE);

	csm_ram #(
		.WIDTH (RW),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Merge the latched write into the row read back from memory.
	always_comb begin
		new_row = ram_rdata;
		case (kind_q)
			KIND_SPEC: begin
				for (int f = 0; f < FIELDS; f++) begin
					if (field_q == FIELD_W'(f)) begin
						new_row[f * FW +: SPEC_W] = {second_q, first_q, mode_q};
					end
				end
			end
			KIND_SLOT: begin
				for (int f = 0; f < FIELDS; f++) begin
					for (int s = 0; s < LIST_SLOTS; s++) begin
						if ((field_q == FIELD_W'(f)) && (second_q == VAL_W'(s))) begin
							new_row[f * FW + SPEC_W + s * VAL_W +: VAL_W] = first_q;
						end
					end
				end
			end
			KIND_ENABLE: begin
				new_row[EN_BIT] = first_q[0];
			end
			default: begin
			end
		endcase
	end

	assign now_val[0] = VAL_W'(min_q);
	assign now_val[1] = VAL_W'(hour_q);
	assign now_val[2] = VAL_W'(dom_q);
	assign now_val[3] = VAL_W'(mon_q);
	assign now_val[4] = VAL_W'(dow_q);

	for (genvar g = 0; g < FIELDS; g++) begin : g_field
		csm_field_match #(
			.LIST_SLOTS (LIST_SLOTS)
		) u_match (
			.spec  (ram_rdata[g * FW +: FW]),
			.value (now_val[g]),
			.hit   (fld_hit[g])
		);
	end

	assign entry_hit = vld_s1 && ram_rdata[EN_BIT] && (&fld_hit);
	assign out_free  = !out_vld_q || m_axis_tready;
	// A new match must push the held one out; without room in the output register the scan waits.
	assign scan_adv  = !(entry_hit && pend_vld_q && !out_free);
	assign scan_more = (rd_addr_q != CW'(ENTRIES));
	// The output register takes the held match when a newer match pushes it out during the
	// scan, or when the tick closes.
	assign out_load  = ((state_q == ST_SCAN) && scan_adv && entry_hit && pend_vld_q) ||
	                   ((state_q == ST_FLUSH) && pend_vld_q && out_free);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rd_addr_q[AW-1:0];
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = rd_addr_q[AW-1:0];
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_WR_READ: begin
				ram_re    = 1'b1;
				ram_raddr = AW'(entry_q);
			end
			ST_WR_MODIFY: begin
				ram_we    = 1'b1;
				ram_waddr = AW'(entry_q);
				ram_wdata = new_row;
			end
			ST_SCAN: begin
				ram_re = scan_adv && scan_more;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			kind_q     <= KIND_SPEC;
			entry_q    <= '0;
			field_q    <= '0;
			mode_q     <= '0;
			first_q    <= '0;
			second_q   <= '0;
			min_q      <= '0;
			hour_q     <= '0;
			dom_q      <= '0;
			mon_q      <= '0;
			dow_q      <= '0;
			rd_addr_q  <= '0;
			vld_s1     <= 1'b0;
			idx_s1     <= '0;
			pend_vld_q <= 1'b0;
			pend_idx_q <= '0;
			out_vld_q  <= 1'b0;
			out_idx_q  <= '0;
			out_last_q <= 1'b0;
		end else begin
			// A taken result leaves unless a new one is loaded in the same cycle.
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					if (rd_addr_q == CW'(ENTRIES - 1)) begin
						rd_addr_q <= '0;
						state_q   <= ST_IDLE;
					end else begin
						rd_addr_q <= rd_addr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						kind_q    <= in_kind;
						entry_q   <= in_entry;
						field_q   <= in_field;
						mode_q    <= s_axis_tdata[OFF_MODE +: MODE_W];
						first_q   <= s_axis_tdata[OFF_FIRST +: VAL_W];
						second_q  <= in_second;
						min_q     <= s_axis_tdata[OFF_MIN +: MIN_W];
						hour_q    <= s_axis_tdata[OFF_HOUR +: HOUR_W];
						dom_q     <= s_axis_tdata[OFF_DOM +: DOM_W];
						mon_q     <= s_axis_tdata[OFF_MON +: MON_W];
						// A weekday of zero is taken as Sunday.
						dow_q     <= (in_dow == '0) ? SUNDAY : in_dow;
						rd_addr_q <= '0;
						vld_s1    <= 1'b0;
						if (in_kind == KIND_TICK) begin
							state_q <= ST_SCAN;
						end else if (write_ok) begin
							state_q <= ST_WR_READ;
						end
					end
				end
				ST_WR_READ: begin
					state_q <= ST_WR_MODIFY;
				end
				ST_WR_MODIFY: begin
					state_q <= ST_IDLE;
				end
				ST_SCAN: begin
					if (scan_adv) begin
						if (entry_hit) begin
							if (pend_vld_q) begin
								out_idx_q  <= ENTRY_W'(pend_idx_q);
								out_last_q <= 1'b0;
							end
							pend_vld_q <= 1'b1;
							pend_idx_q <= idx_s1;
						end
						if (scan_more) begin
							vld_s1    <= 1'b1;
							idx_s1    <= rd_addr_q[AW-1:0];
							rd_addr_q <= rd_addr_q + 1'b1;
						end else begin
							vld_s1  <= 1'b0;
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (!pend_vld_q) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						out_idx_q  <= ENTRY_W'(pend_idx_q);
						out_last_q <= 1'b1;
						pend_vld_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = OUT_DATA_W'(out_idx_q);
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTH
	// A held match never survives past its tick.
	a_idle_no_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_vld_q)
		else $error("held match left over after a tick");

	// The scan only reads; no write may disturb the rows it walks.
	a_scan_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> !ram_we)
		else $error("memory write during a scan");

	// Closing a tick with a held match must present it as the last result.
	a_flush_last: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLUSH && pend_vld_q && out_free) |=>
		(m_axis_tvalid && m_axis_tlast && state_q == ST_IDLE))
		else $error("final match of a tick not marked last");

	// Every row at the memory output during a scan lies inside the table.
	a_scan_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && vld_s1) |-> (int'(idx_s1) < ENTRIES))
		else $error("scan row outside the table");
`endif

endmodule

`default_nettype wire

[rtl/csm_ram.sv]
`timescale 1ns / 1ps
`default_nettype none

module csm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/csm_field_match.sv]
`timescale 1ns / 1ps
`default_nettype none

module csm_field_match #(
	parameter int LIST_SLOTS = 8
) (
	input  wire logic [csm_pkg::SPEC_W + LIST_SLOTS * csm_pkg::VAL_W - 1:0] spec,
	input  wire logic [csm_pkg::VAL_W-1:0]                                  value,
	output logic                                                            hit
);

	import csm_pkg::*;

	mode_t            mode;
	logic [VAL_W-1:0] lo;
	logic [VAL_W-1:0] hi;
	logic             list_hit;

	assign mode = mode_t'(spec[MODE_W-1:0]);
	assign lo   = spec[MODE_W +: VAL_W];
	assign hi   = spec[MODE_W + VAL_W +: VAL_W];

	// A slot counts only below the stored count; a count above the slot total covers all slots.
	always_comb begin
		list_hit = 1'b0;
		for (int s = 0; s < LIST_SLOTS; s++) begin
			if ((VAL_W'(s) < hi) && (spec[SPEC_W + s * VAL_W +: VAL_W] == value)) begin
				list_hit = 1'b1;
			end
		end
	end

	always_comb begin
		unique case (mode)
			MODE_ANY:   hit = 1'b1;
			MODE_EXACT: hit = (value == lo);
			MODE_LIST:  hit = list_hit;
			MODE_RANGE: hit = (lo <= value) && (value <= hi);
			default:    hit = 1'b0;
		endcase
	end

endmodule

`default_nettype wire
